>>> rtl/settled_supply_voltage_gauge_top_assert.svh
// Assertion macros for the settled supply voltage gauge.
// Included by the top level, the one module that carries concurrent checks; no other dependencies.
`ifndef SETTLED_SUPPLY_VOLTAGE_GAUGE_TOP_ASSERT_SVH
`define SETTLED_SUPPLY_VOLTAGE_GAUGE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SSVG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Condition in one cycle implies a consequence in the next cycle.
`define SSVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SSVG_ASSERT(label, clk, rst_n, prop)
`define SSVG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ssvg_pkg.sv
// Package for the settled supply voltage gauge: widths, constants, codes, types.
// Used by the shared divider and the top level; depends on nothing.
`default_nettype none

package ssvg_pkg;

  // Field and register widths.
  localparam int ADC_W   = 10;
  localparam int MV_W    = 16;
  localparam int LED_W   = 7;
  localparam int TOL_W   = 8;
  localparam int RUN_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Largest number of LEDs the bar may use.
  localparam int MAX_LEDS = 64;

  // Shared divider geometry: a 24-bit dividend covers both divisions.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Arithmetic constants.
  localparam logic [DIV_NUM_W-1:0] BANDGAP_NUMERATOR = 24'd1125300;
  localparam logic [MV_W-1:0]      COMPARE_RESET     = 16'd9999;
  localparam logic [MV_W-1:0]      MV_SATURATE       = 16'hFFFF;
  localparam logic [RUN_W-1:0]     RUN_MAX           = 3'd7;

  // Register reset values.
  localparam logic [MV_W-1:0]  MIN_MV_RST        = 16'd3350;
  localparam logic [MV_W-1:0]  MAX_MV_RST        = 16'd4000;
  localparam logic [LED_W-1:0] LED_COUNT_RST     = 7'd16;
  localparam logic [MV_W-1:0]  CHARGING_MV_RST   = 16'd4200;
  localparam logic [MV_W-1:0]  COMPLETE_MV_RST   = 16'd4765;
  localparam logic [TOL_W-1:0] TOLERANCE_MV_RST  = 8'd10;
  localparam logic [RUN_W-1:0] STABLE_NEEDED_RST = 3'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_MV        = 3'd0,
    REG_MAX_MV        = 3'd1,
    REG_LED_COUNT     = 3'd2,
    REG_CHARGING_MV   = 3'd3,
    REG_COMPLETE_MV   = 3'd4,
    REG_TOLERANCE_MV  = 3'd5,
    REG_STABLE_NEEDED = 3'd6
  } cfg_reg_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ssvg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ssvg_pkg for widths and the request and response types.
`default_nettype none

module ssvg_div
  import ssvg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] count_r;
  logic [DIV_DEN_W:0]   rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;

  // One restoring step: shift in the next dividend bit and try to subtract.
  logic [DIV_DEN_W:0] rem_shift;
  logic               fits;
  assign rem_shift = {rem_r[DIV_DEN_W-1:0], quo_r[DIV_NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_r};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        count_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        count_r <= count_r - 1'b1;
        if (count_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_shift - {1'b0, den_r} : rem_shift;
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/settled_supply_voltage_gauge_top.sv
// Settled supply voltage gauge. Each accepted word runs through the 24-step shared divider
// once, and a second time when the bar lies strictly between its limits.
// One word at a time: a new word is taken only once the sequencer is back in S_IDLE,
// which for a word that gives a result waits until the output register is free.
// Reset (synchronous, rst_n low) loads register defaults, compare value 9999, run zero.
`default_nettype none
`include "settled_supply_voltage_gauge_top_assert.svh"

module settled_supply_voltage_gauge_top
  import ssvg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [15:0]           in_tdata,   // [9:0] adc_code, [15:10] zero
  // Result stream.
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [31:0]           out_tdata,  // [15:0] supply_mv, [22:16] bar_level,
                                                 // [23] charging, [24] charge_complete,
                                                 // [31:25] zero
  // Configuration writes.
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_SAT, S_CHECK, S_BAR, S_DIV2, S_EMIT
  } state_t;

  // Configuration registers.
  logic [MV_W-1:0]  min_mv_r;
  logic [MV_W-1:0]  max_mv_r;
  logic [LED_W-1:0] led_count_r;
  logic [MV_W-1:0]  charging_mv_r;
  logic [MV_W-1:0]  complete_mv_r;
  logic [TOL_W-1:0] tolerance_mv_r;
  logic [RUN_W-1:0] stable_needed_r;

  // Sequencer and item state.
  state_t           state_r;
  logic [MV_W-1:0]  prev_mv_r;
  logic [RUN_W-1:0] run_r;
  logic [ADC_W-1:0] code_r;
  logic [MV_W-1:0]  mv_r;
  logic [LED_W-1:0] bar_r;
  div_req_t         div_req_r;
  div_rsp_t         div_rsp;

  // Output register.
  logic             out_valid_r;
  logic [MV_W-1:0]  out_mv_r;
  logic [LED_W-1:0] out_bar_r;
  logic             out_charging_r;
  logic             out_complete_r;

  ssvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // Configuration write port; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mv_r        <= MIN_MV_RST;
      max_mv_r        <= MAX_MV_RST;
      led_count_r     <= LED_COUNT_RST;
      charging_mv_r   <= CHARGING_MV_RST;
      complete_mv_r   <= COMPLETE_MV_RST;
      tolerance_mv_r  <= TOLERANCE_MV_RST;
      stable_needed_r <= STABLE_NEEDED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_MV:        min_mv_r        <= cfg_wdata;
        REG_MAX_MV:        max_mv_r        <= cfg_wdata;
        REG_LED_COUNT:     led_count_r     <= cfg_wdata[LED_W-1:0];
        REG_CHARGING_MV:   charging_mv_r   <= cfg_wdata;
        REG_COMPLETE_MV:   complete_mv_r   <= cfg_wdata;
        REG_TOLERANCE_MV:  tolerance_mv_r  <= cfg_wdata[TOL_W-1:0];
        REG_STABLE_NEEDED: stable_needed_r <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective LED count and run length.
  logic [LED_W-1:0] leds_eff;
  logic [RUN_W-1:0] need_eff;
  assign leds_eff = (led_count_r == '0) ? LED_W'(1) :
                    ({1'b0, led_count_r} > 8'(MAX_LEDS)) ? LED_W'(MAX_LEDS) : led_count_r;
  assign need_eff = (stable_needed_r == '0) ? RUN_W'(1) : stable_needed_r;

  // Quotient to millivolts, saturated; a zero code reads as zero.
  logic [MV_W-1:0] mv_calc;
  assign mv_calc = (code_r == '0) ? '0 :
                   (div_rsp.quotient[DIV_NUM_W-1:MV_W] != '0) ? MV_SATURATE :
                   div_rsp.quotient[MV_W-1:0];

  // Stability test against the previous reading.
  logic [MV_W-1:0]  diff_mv;
  logic             stable;
  logic [RUN_W-1:0] run_inc;
  logic             accept;
  assign diff_mv = (mv_r >= prev_mv_r) ? mv_r - prev_mv_r : prev_mv_r - mv_r;
  assign stable  = diff_mv <= {{(MV_W-TOL_W){1'b0}}, tolerance_mv_r};
  assign run_inc = !stable ? '0 : (run_r == RUN_MAX) ? RUN_MAX : run_r + 1'b1;
  assign accept  = run_inc >= need_eff;

  // Rounded bar division operands.
  logic [MV_W-1:0]      span_mv;
  logic [DIV_NUM_W-1:0] bar_num;
  logic [DIV_DEN_W-1:0] bar_den;
  logic                 bar_divide;
  assign span_mv = mv_r - min_mv_r;
  assign bar_num = {8'b0, span_mv} * {17'b0, leds_eff}
                 + {18'b0, leds_eff[LED_W-1:1]};
  assign bar_den = {1'b0, max_mv_r - min_mv_r} + DIV_DEN_W'(1);
  assign bar_divide = (mv_r < max_mv_r) && (mv_r > min_mv_r);

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      prev_mv_r       <= COMPARE_RESET;
      run_r           <= '0;
      div_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // The divider starts on a new word and on a bar strictly between its limits.
      div_req_r.start <= (state_r == S_IDLE && in_tvalid) ||
                         (state_r == S_BAR && bar_divide);
      // The output word is loaded from S_EMIT and cleared once taken.
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            code_r             <= in_tdata[ADC_W-1:0];
            div_req_r.dividend <= BANDGAP_NUMERATOR;
            div_req_r.divisor  <= {{(DIV_DEN_W-ADC_W){1'b0}}, in_tdata[ADC_W-1:0]};
            state_r            <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          mv_r    <= mv_calc;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (accept) begin
            prev_mv_r <= COMPARE_RESET;
            run_r     <= '0;
            state_r   <= S_BAR;
          end else begin
            prev_mv_r <= mv_r;
            run_r     <= run_inc;
            state_r   <= S_IDLE;
          end
        end
        S_BAR: begin
          if (mv_r >= max_mv_r) begin
            bar_r   <= leds_eff;
            state_r <= S_EMIT;
          end else if (mv_r <= min_mv_r) begin
            bar_r   <= LED_W'(1);
            state_r <= S_EMIT;
          end else begin
            div_req_r.dividend <= bar_num;
            div_req_r.divisor  <= bar_den;
            state_r            <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            bar_r   <= div_rsp.quotient[LED_W-1:0] + LED_W'(1);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_mv_r       <= mv_r;
            out_bar_r      <= bar_r;
            out_charging_r <= mv_r > charging_mv_r;
            out_complete_r <= mv_r >= complete_mv_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_complete_r, out_charging_r, out_bar_r, out_mv_r};

  // An accepted word always starts the sequencer.
  `SSVG_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE)
  // The divider only finishes while the sequencer waits for it.
  `SSVG_ASSERT(a_done_expected, clk, rst_n,
               !div_rsp.done || state_r == S_DIV1 || state_r == S_DIV2)
  // A pending result carries a bar level within the effective LED count.
  `SSVG_ASSERT(a_bar_range, clk, rst_n,
               !out_valid_r || (out_bar_r != '0 && out_bar_r <= leds_eff))
  // The run is cleared on acceptance before it can saturate.
  `SSVG_ASSERT(a_run_bound, clk, rst_n, run_r != RUN_MAX)
  // The rounding division runs only strictly between the bar limits.
  `SSVG_ASSERT(a_div2_span, clk, rst_n,
               state_r != S_DIV2 || (mv_r > min_mv_r && mv_r < max_mv_r))

endmodule

`default_nettype wire

>>> tb/tb_settled_supply_voltage_gauge_top.sv
// Self-checking testbench for the settled supply voltage gauge: directed and random
// conversion codes, register settings and stream stalls, checked against a local predictor.
// Depends on ssvg_pkg and settled_supply_voltage_gauge_top only.
`timescale 1ns / 1ps

module tb_settled_supply_voltage_gauge_top;
  import ssvg_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_SETTLE = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Register set at the block's widths.
  typedef struct packed {
    logic [MV_W-1:0]  min_mv;
    logic [MV_W-1:0]  max_mv;
    logic [LED_W-1:0] led_count;
    logic [MV_W-1:0]  charging_mv;
    logic [MV_W-1:0]  complete_mv;
    logic [TOL_W-1:0] tolerance_mv;
    logic [RUN_W-1:0] stable_needed;
  } gauge_cfg_t;

  // One accepted reading as it leaves the block.
  typedef struct packed {
    logic [MV_W-1:0]  supply_mv;
    logic [LED_W-1:0] bar_level;
    logic             charging;
    logic             charge_complete;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and the settling state.
  gauge_cfg_t       model_cfg;
  logic [MV_W-1:0]  last_reading_mv;
  logic [RUN_W-1:0] stable_count;
  reading_t         expected_readings[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int holds_requested = 0;
  int holds_served = 0;

  settled_supply_voltage_gauge_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_problem(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Conversion code to millivolts, saturated, zero code giving zero.
  function automatic logic [MV_W-1:0] code_to_millivolts(input logic [ADC_W-1:0] code);
    int q;
    if (code == '0) return '0;
    q = int'(BANDGAP_NUMERATOR) / int'(code);
    if (q > int'(MV_SATURATE)) q = int'(MV_SATURATE);
    return MV_W'(q);
  endfunction

  // Bar level with the LED count clamped to 1..MAX_LEDS and rounding in between.
  function automatic logic [LED_W-1:0] bar_leds(input logic [MV_W-1:0] mv);
    longint n;
    longint span;
    longint offset;
    n = longint'(model_cfg.led_count);
    if (n == 0) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;
    if (mv >= model_cfg.max_mv) return LED_W'(n);
    if (mv <= model_cfg.min_mv) return LED_W'(1);
    offset = longint'(mv) - longint'(model_cfg.min_mv);
    span = longint'(model_cfg.max_mv) - longint'(model_cfg.min_mv) + 1;
    return LED_W'(1 + (offset * n + n / 2) / span);
  endfunction

  // Advance the settling state for one accepted code and queue a reading if it settles.
  task automatic predict_reading(input logic [ADC_W-1:0] code);
    logic [MV_W-1:0]  mv;
    logic [MV_W-1:0]  step;
    logic [RUN_W-1:0] need;
    reading_t         r;
    mv = code_to_millivolts(code);
    step = (mv >= last_reading_mv) ? mv - last_reading_mv : last_reading_mv - mv;
    need = (model_cfg.stable_needed == '0) ? RUN_W'(1) : model_cfg.stable_needed;
    if (step <= MV_W'(model_cfg.tolerance_mv)) begin
      if (stable_count < RUN_MAX) stable_count++;
    end else begin
      stable_count = '0;
    end
    last_reading_mv = mv;
    if (stable_count >= need) begin
      r.supply_mv = mv;
      r.bar_level = bar_leds(mv);
      r.charging = (mv > model_cfg.charging_mv);
      r.charge_complete = (mv >= model_cfg.complete_mv);
      expected_readings.push_back(r);
      last_reading_mv = COMPARE_RESET;
      stable_count = '0;
    end
  endtask

  // Offer one code word and wait for it to be taken; bursts end in a random gap.
  task automatic send_code(input logic [ADC_W-1:0] code);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {{(16 - ADC_W){1'b0}}, code};
    do @(posedge clk); while (!in_tready);
    predict_reading(code);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end
  endtask

  // Stop offering words, let every reading come out, then let the block go quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_MIN_MV:        model_cfg.min_mv = value;
      REG_MAX_MV:        model_cfg.max_mv = value;
      REG_LED_COUNT:     model_cfg.led_count = value[LED_W-1:0];
      REG_CHARGING_MV:   model_cfg.charging_mv = value;
      REG_COMPLETE_MV:   model_cfg.complete_mv = value;
      REG_TOLERANCE_MV:  model_cfg.tolerance_mv = value[TOL_W-1:0];
      REG_STABLE_NEEDED: model_cfg.stable_needed = value[RUN_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; narrow registers get junk in the unused upper bits.
  task automatic apply_config(input gauge_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MIN_MV, c.min_mv);
    write_reg(REG_MAX_MV, c.max_mv);
    write_reg(REG_LED_COUNT, {junk[CFG_DATA_W-1:LED_W], c.led_count});
    write_reg(REG_CHARGING_MV, c.charging_mv);
    write_reg(REG_COMPLETE_MV, c.complete_mv);
    write_reg(REG_TOLERANCE_MV, {junk[CFG_DATA_W-1:TOL_W], c.tolerance_mv});
    write_reg(REG_STABLE_NEEDED, {junk[CFG_DATA_W-1:RUN_W], c.stable_needed});
    write_reg(REG_UNUSED, junk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [MV_W-1:0] pick_mv(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MV_SATURATE;
      2: return MV_W'($urandom_range(0, 65535));
      default: return MV_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic gauge_cfg_t random_settings();
    gauge_cfg_t c;
    c.min_mv = pick_mv(3000, 3800);
    c.max_mv = pick_mv(3600, 4600);
    c.led_count = LED_W'($urandom_range(0, 127));
    c.charging_mv = pick_mv(3500, 5000);
    c.complete_mv = pick_mv(4000, 5200);
    case ($urandom_range(0, 5))
      0: c.tolerance_mv = '0;
      1: c.tolerance_mv = '1;
      2: c.tolerance_mv = TOL_W'($urandom_range(0, 255));
      default: c.tolerance_mv = TOL_W'($urandom_range(0, 30));
    endcase
    c.stable_needed = RUN_W'($urandom_range(0, 7));
    return c;
  endfunction

  // Codes that land mostly in the interesting voltage range.
  function automatic int pick_code();
    case ($urandom_range(0, 19))
      0, 1, 2:     return $urandom_range(0, 20);
      3, 4, 5:     return $urandom_range(900, 1023);
      6, 7, 8, 9:  return $urandom_range(0, 1023);
      default:     return $urandom_range(200, 400);
    endcase
  endfunction

  function automatic logic [ADC_W-1:0] jitter_code(input int base, input int spread);
    int c;
    c = base + $urandom_range(0, 2 * spread) - spread;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    return ADC_W'(c);
  endfunction

  // Receiver: segments of differing stall patterns, plus long hold-offs on request.
  int ready_mode = 0;
  int ready_left = 0;
  int ready_period = 1;
  int ready_phase = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(1, 64);
        ready_period = $urandom_range(2, 9);
      end
      ready_left--;
      ready_phase++;
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (ready_phase % ready_period == 0);
      endcase
    end
  end

  // Compare each result word with the oldest predicted reading.
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.supply_mv = out_tdata[15:0];
      got.bar_level = out_tdata[22:16];
      got.charging = out_tdata[23];
      got.charge_complete = out_tdata[24];
      if (expected_readings.size() == 0) begin
        report_problem($sformatf("result with no reading waiting: mv %0d", got.supply_mv));
      end else begin
        want = expected_readings.pop_front();
        if (got.supply_mv != want.supply_mv)
          report_problem($sformatf("supply_mv expected %0d got %0d",
                                   want.supply_mv, got.supply_mv));
        if (got.bar_level != want.bar_level)
          report_problem($sformatf("bar_level expected %0d got %0d (mv %0d)",
                                   want.bar_level, got.bar_level, want.supply_mv));
        if (got.charging != want.charging)
          report_problem($sformatf("charging expected %0d got %0d (mv %0d)",
                                   want.charging, got.charging, want.supply_mv));
        if (got.charge_complete != want.charge_complete)
          report_problem($sformatf("charge_complete expected %0d got %0d (mv %0d)",
                                   want.charge_complete, got.charge_complete,
                                   want.supply_mv));
      end
    end
  end

  // Reset values: zero code, a mid-range bar and a fully charged supply.
  task automatic test_directed_defaults();
    repeat (5) send_code(ADC_W'(0));
    repeat (5) send_code(ADC_W'(300));
    repeat (5) send_code(ADC_W'(236));
  endtask

  // Register extremes: clamped LED counts, zero run length, equal bar limits, saturation.
  task automatic test_directed_extremes();
    gauge_cfg_t c;
    wait_idle();
    c.min_mv = '0;
    c.max_mv = MV_SATURATE;
    c.led_count = '0;
    c.charging_mv = '0;
    c.complete_mv = MV_SATURATE;
    c.tolerance_mv = '1;
    c.stable_needed = '0;
    apply_config(c);
    send_code(ADC_W'(113));
    send_code(ADC_W'(1023));
    send_code(ADC_W'(1023));
    send_code(ADC_W'(17));
    send_code(ADC_W'(17));
    wait_idle();
    c.min_mv = MV_W'(3000);
    c.max_mv = MV_W'(3000);
    c.led_count = '1;
    c.charging_mv = MV_SATURATE;
    c.complete_mv = '0;
    c.tolerance_mv = '0;
    c.stable_needed = '1;
    apply_config(c);
    repeat (8) send_code(ADC_W'(300));
  endtask

  // Random settings per phase; mostly settling runs, some noise and broken runs.
  task automatic test_random_settings();
    int phase_end;
    int base;
    int len;
    int need;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      apply_config(random_settings());
      need = (model_cfg.stable_needed == '0) ? 1 : int'(model_cfg.stable_needed);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          7: send_code(ADC_W'($urandom_range(0, 1023)));
          8: begin
            base = pick_code();
            repeat (need - 1) send_code(ADC_W'(base));
            send_code(ADC_W'(base ^ 512));
          end
          9: repeat ($urandom_range(1, 4)) send_code(ADC_W'($urandom_range(0, 1023)));
          default: begin
            base = pick_code();
            len = need + $urandom_range(0, 2);
            repeat (len) send_code(jitter_code(base, ($urandom_range(0, 3) == 0) ? 1 : 0));
          end
        endcase
      end
    end
  endtask

  // Long receiver hold-off while words keep coming, so the block backs up its input.
  task automatic test_backpressure();
    gauge_cfg_t c;
    wait_idle();
    c.min_mv = MV_W'(3300);
    c.max_mv = MV_W'(4100);
    c.led_count = LED_W'(20);
    c.charging_mv = CHARGING_MV_RST;
    c.complete_mv = COMPLETE_MV_RST;
    c.tolerance_mv = '1;
    c.stable_needed = RUN_W'(1);
    apply_config(c);
    holds_requested++;
    repeat (30) send_code(jitter_code(300, 1));
  endtask

  initial begin
    model_cfg.min_mv = MIN_MV_RST;
    model_cfg.max_mv = MAX_MV_RST;
    model_cfg.led_count = LED_COUNT_RST;
    model_cfg.charging_mv = CHARGING_MV_RST;
    model_cfg.complete_mv = COMPLETE_MV_RST;
    model_cfg.tolerance_mv = TOLERANCE_MV_RST;
    model_cfg.stable_needed = STABLE_NEEDED_RST;
    last_reading_mv = COMPARE_RESET;
    stable_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_directed_extremes();
    test_random_settings();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
